>>> hdl/tnu_pkg.sv
// shared types for the triangle normal unit
`default_nettype none

package tnu_pkg;

   // per-item flags carried alongside the arithmetic chains
   typedef struct packed {
      logic       use_unit;  // normalize and report length
      logic [2:0] neg;       // sign of each raw normal component
   } side_type;

endpackage

`default_nettype wire

>>> hdl/tnu_div_cell.sv
// one restoring division step: one quotient bit per cell
`default_nettype none

module tnu_div_cell #(
   parameter int RW = 136,
   parameter int QW = 33
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [RW-1:0] den,
   input  logic [RW-1:0] rem_i,
   input  logic [QW-1:0] pend_i,
   input  logic [QW-1:0] quo_i,
   output logic [RW-1:0] rem_o,
   output logic [QW-1:0] pend_o,
   output logic [QW-1:0] quo_o
);

   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] pend_ff, pend_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [RW:0]   r2;
   logic [RW+1:0] diff;
   logic          ge;

   // shift in the next dividend bit, trial subtract
   always_comb begin
      r2      = {rem_i, pend_i[QW-1]};
      diff    = {1'b0, r2} - {2'b00, den};
      ge      = !diff[RW+1];
      rem_in  = ge ? diff[RW-1:0] : r2[RW-1:0];
      pend_in = {pend_i[QW-2:0], 1'b0};
      quo_in  = {quo_i[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         pend_ff <= pend_in;
         quo_ff  <= quo_in;
      end
   end

   assign rem_o  = rem_ff;
   assign pend_o = pend_ff;
   assign quo_o  = quo_ff;

endmodule

`default_nettype wire

>>> hdl/tnu_sqrt_cell.sv
// one digit-by-digit square root step: one root bit per cell
`default_nettype none

module tnu_sqrt_cell #(
   parameter int K = 52
) (
   input  logic           clock,
   input  logic           advance,
   input  logic [K+1:0]   rem_i,
   input  logic [K-1:0]   root_i,
   input  logic [2*K-1:0] rad_i,
   output logic [K+1:0]   rem_o,
   output logic [K-1:0]   root_o,
   output logic [2*K-1:0] rad_o
);

   localparam int AW = K + 4;

   logic [K+1:0]   rem_ff, rem_in;
   logic [K-1:0]   root_ff, root_in;
   logic [2*K-1:0] rad_ff, rad_in;
   logic [AW-1:0]  acc;
   logic [AW-1:0]  trial;
   logic [AW:0]    diff;
   logic           ge;

   // bring down two radicand bits, try 4*root+1
   always_comb begin
      acc     = {rem_i, rad_i[2*K-1 -: 2]};
      trial   = AW'({root_i, 2'b01});
      diff    = {1'b0, acc} - {1'b0, trial};
      ge      = !diff[AW];
      rem_in  = ge ? diff[K+1:0] : acc[K+1:0];
      root_in = {root_i[K-2:0], ge};
      rad_in  = {rad_i[2*K-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign rad_o  = rad_ff;

endmodule

`default_nettype wire

>>> hdl/tnu_front.sv
// edges, cross product, squared components and squared length (7 stages)
`default_nettype none

module tnu_front import tnu_pkg::*; #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [2:0][W-1:0]      a_pt,
   input  logic [2:0][W-1:0]      b_pt,
   input  logic [2:0][W-1:0]      c_pt,
   input  logic                   want,
   output logic [2:0][4*W+1:0]    sq_o,
   output logic [4*W+3:0]         sum_o,
   output logic [2:0][W-1:0]      raw_o,
   output side_type               side_o
);

   localparam int NW  = 2 * W + 1;
   localparam int H   = W + 1;
   localparam int SQW = 4 * W + 2;
   localparam int SW  = 4 * W + 4;
   localparam logic [NW-1:0] POS_LIM = (NW'(1) << (W - 1)) - NW'(1);
   localparam logic [NW-1:0] NEG_LIM = NW'(1) << (W - 1);

   logic signed [W:0]      u_ff [3];
   logic signed [W:0]      v_ff [3];
   logic signed [2*W+1:0]  pa_ff [3];
   logic signed [2*W+1:0]  pb_ff [3];
   logic signed [2*W+1:0]  n_ff [3];
   logic [NW-1:0]          mag_ff [3];
   logic [2:0]             neg_ff;
   logic [2*W-1:0]         hh_ff [3];
   logic [2*W:0]           hl_ff [3];
   logic [2*W+1:0]         ll_ff [3];
   logic [2:0][SQW-1:0]    sq_ff;
   logic [2:0][SQW-1:0]    sq7_ff;
   logic [SW-1:0]          sum_ff;
   logic [3:0]             want_ff;
   logic [2:0][W-1:0]      raw5_ff, raw6_ff, raw7_ff;
   side_type               side5_ff, side6_ff, side7_ff;
   logic [2:0][W-1:0]      raw_in;
   side_type               side_in;

   // want flag follows the first four stages
   always_ff @(posedge clock) begin
      if (advance) begin
         want_ff <= {want_ff[2:0], want};
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < 3; gi++) begin : g_comp
         localparam int J = (gi + 1) % 3;
         localparam int K = (gi + 2) % 3;
         always_ff @(posedge clock) begin
            if (advance) begin
               // edges b-a and c-a
               u_ff[gi]  <= $signed({b_pt[gi][W-1], b_pt[gi]})
                            - $signed({a_pt[gi][W-1], a_pt[gi]});
               v_ff[gi]  <= $signed({c_pt[gi][W-1], c_pt[gi]})
                            - $signed({a_pt[gi][W-1], a_pt[gi]});
               // cross product partial products
               pa_ff[gi] <= u_ff[J] * v_ff[K];
               pb_ff[gi] <= u_ff[K] * v_ff[J];
               n_ff[gi]  <= pa_ff[gi] - pb_ff[gi];
               // sign and magnitude
               neg_ff[gi] <= n_ff[gi][2*W+1];
               mag_ff[gi] <= n_ff[gi][2*W+1] ? NW'(-n_ff[gi]) : NW'(n_ff[gi]);
               // square in halves
               hh_ff[gi] <= mag_ff[gi][NW-1:H] * mag_ff[gi][NW-1:H];
               hl_ff[gi] <= (2*W+1)'(mag_ff[gi][NW-1:H]) * (2*W+1)'(mag_ff[gi][H-1:0]);
               ll_ff[gi] <= mag_ff[gi][H-1:0] * mag_ff[gi][H-1:0];
               sq_ff[gi] <= (SQW'(hh_ff[gi]) << (2 * H))
                            + (SQW'(hl_ff[gi]) << (H + 1)) + SQW'(ll_ff[gi]);
            end
         end
      end
   endgenerate

   // raw normal: drop fraction bits, saturate; normalize only a nonzero normal
   always_comb begin
      logic [NW-1:0] q;
      logic [NW-1:0] v;
      for (int i = 0; i < 3; i++) begin
         q = mag_ff[i] >> F;
         if (neg_ff[i]) begin
            v = (q > NEG_LIM) ? NEG_LIM : q;
            raw_in[i] = W'(-v);
         end else begin
            v = (q > POS_LIM) ? POS_LIM : q;
            raw_in[i] = W'(v);
         end
      end
      side_in.use_unit = want_ff[3] && ((|mag_ff[0]) || (|mag_ff[1]) || (|mag_ff[2]));
      side_in.neg      = neg_ff;
   end

   // flags, raw normal and squared length
   always_ff @(posedge clock) begin
      if (advance) begin
         raw5_ff  <= raw_in;
         side5_ff <= side_in;
         raw6_ff  <= raw5_ff;
         side6_ff <= side5_ff;
         raw7_ff  <= raw6_ff;
         side7_ff <= side6_ff;
         sq7_ff   <= sq_ff;
         sum_ff   <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      end
   end

   assign sq_o   = sq7_ff;
   assign sum_o  = sum_ff;
   assign raw_o  = raw7_ff;
   assign side_o = side7_ff;

endmodule

`default_nettype wire

>>> hdl/triangle_normal_unit_core.sv
// triangle face normal: cross product, optional unit normal and length
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  req_a_*, req_b_*, req_c_*, req_want_unit
//  rsp      out  rsp_valid/rsp_ready  rsp_norm_x/y/z, rsp_magnitude
//
// fully pipelined: one item per clock while no result stalls the pipeline.
// the chains of division and square root cells, one result bit per cell, set
// the depth; each division cell does one wide compare and subtract.
// reset clears the valid bits only. a stalled result holds the whole pipeline.
`default_nettype none

module triangle_normal_unit_core import tnu_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_c_x,
   input  logic signed [COORD_WIDTH-1:0] req_c_y,
   input  logic signed [COORD_WIDTH-1:0] req_c_z,
   input  logic                          req_want_unit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_norm_x,
   output logic signed [COORD_WIDTH-1:0] rsp_norm_y,
   output logic signed [COORD_WIDTH-1:0] rsp_norm_z,
   output logic [COORD_WIDTH-1:0]        rsp_magnitude
);

   localparam int W     = COORD_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int SQW   = 4 * W + 2;
   localparam int SW    = 4 * W + 4;
   localparam int QW    = 2 * F + 1;
   localparam int MK    = 2 * W + 2 - F;
   localparam int LC    = (MK > 3 * F + 2) ? MK : 3 * F + 2;
   localparam int KU    = LC - QW;
   localparam int KM    = LC;
   localparam int FRONT = 7;
   localparam int NV    = FRONT + LC;
   localparam int EW    = KU + W;
   localparam int MEW   = KM + W;
   localparam logic [EW-1:0]  U_POS = (EW'(1) << (W - 1)) - EW'(1);
   localparam logic [EW-1:0]  U_NEG = EW'(1) << (W - 1);
   localparam logic [MEW-1:0] M_MAX = (MEW'(1) << W) - MEW'(1);

   logic                  advance;
   logic [NV-1:0]         valid_ff;
   logic                  out_valid_ff;
   logic [2:0][SQW-1:0]   sq;
   logic [SW-1:0]         sum;
   logic [2:0][W-1:0]     raw;
   side_type              side;

   // the pipeline moves unless a result sits unaccepted
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[NV-2:0], req_valid};
         out_valid_ff <= valid_ff[NV-1];
      end
   end

   tnu_front #(.W(W), .F(F)) u_front (
      .clock   (clock),
      .advance (advance),
      .a_pt    ({req_a_z, req_a_y, req_a_x}),
      .b_pt    ({req_b_z, req_b_y, req_b_x}),
      .c_pt    ({req_c_z, req_c_y, req_c_x}),
      .want    (req_want_unit),
      .sq_o    (sq),
      .sum_o   (sum),
      .raw_o   (raw),
      .side_o  (side)
   );

   // flags and raw normal ride along the cell chains
   logic [2:0][W-1:0] raw_ff [LC];
   side_type          side_ff [LC];
   logic [SW-1:0]     den_ff [QW-1];

   genvar gk, gc;
   generate
      for (gk = 0; gk < LC; gk++) begin : g_side
         if (gk == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (advance) begin
                  raw_ff[gk]  <= raw;
                  side_ff[gk] <= side;
               end
            end
         end else begin : g_next
            always_ff @(posedge clock) begin
               if (advance) begin
                  raw_ff[gk]  <= raw_ff[gk-1];
                  side_ff[gk] <= side_ff[gk-1];
               end
            end
         end
      end

      // divisor copy for each later division cell
      for (gk = 0; gk < QW - 1; gk++) begin : g_den
         if (gk == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (advance) den_ff[gk] <= sum;
            end
         end else begin : g_next
            always_ff @(posedge clock) begin
               if (advance) den_ff[gk] <= den_ff[gk-1];
            end
         end
      end
   endgenerate

   // unit normal: q = n^2 * 2^2F / |n|^2, then sqrt(q)
   logic [SW-1:0]     drem  [3][QW+1];
   logic [QW-1:0]     dpend [3][QW+1];
   logic [QW-1:0]     dquo  [3][QW+1];
   logic [KU+1:0]     urem  [3][KU+1];
   logic [KU-1:0]     uroot [3][KU+1];
   logic [2*KU-1:0]   urad  [3][KU+1];

   generate
      for (gc = 0; gc < 3; gc++) begin : g_unit
         assign drem[gc][0]  = SW'(sq[gc] >> 1);
         assign dpend[gc][0] = {sq[gc][0], {(QW-1){1'b0}}};
         assign dquo[gc][0]  = '0;
         for (gk = 0; gk < QW; gk++) begin : g_div
            tnu_div_cell #(.RW(SW), .QW(QW)) u_div (
               .clock   (clock),
               .advance (advance),
               .den     ((gk == 0) ? sum : den_ff[(gk == 0) ? 0 : gk-1]),
               .rem_i   (drem[gc][gk]),
               .pend_i  (dpend[gc][gk]),
               .quo_i   (dquo[gc][gk]),
               .rem_o   (drem[gc][gk+1]),
               .pend_o  (dpend[gc][gk+1]),
               .quo_o   (dquo[gc][gk+1])
            );
         end
         assign urem[gc][0]  = '0;
         assign uroot[gc][0] = '0;
         assign urad[gc][0]  = (2*KU)'(dquo[gc][QW]);
         for (gk = 0; gk < KU; gk++) begin : g_sqrt
            tnu_sqrt_cell #(.K(KU)) u_sqrt (
               .clock   (clock),
               .advance (advance),
               .rem_i   (urem[gc][gk]),
               .root_i  (uroot[gc][gk]),
               .rad_i   (urad[gc][gk]),
               .rem_o   (urem[gc][gk+1]),
               .root_o  (uroot[gc][gk+1]),
               .rad_o   (urad[gc][gk+1])
            );
         end
      end
   endgenerate

   // length: sqrt(|n|^2 / 2^2F)
   logic [KM+1:0]   mrem  [KM+1];
   logic [KM-1:0]   mroot [KM+1];
   logic [2*KM-1:0] mrad  [KM+1];

   assign mrem[0]  = '0;
   assign mroot[0] = '0;
   assign mrad[0]  = (2*KM)'(sum >> (2 * F));

   generate
      for (gk = 0; gk < KM; gk++) begin : g_mag
         tnu_sqrt_cell #(.K(KM)) u_sqrt (
            .clock   (clock),
            .advance (advance),
            .rem_i   (mrem[gk]),
            .root_i  (mroot[gk]),
            .rad_i   (mrad[gk]),
            .rem_o   (mrem[gk+1]),
            .root_o  (mroot[gk+1]),
            .rad_o   (mrad[gk+1])
         );
      end
   endgenerate

   // result select and saturation
   logic [2:0][W-1:0] norm_ff, norm_in;
   logic [W-1:0]      magnitude_ff, magnitude_in;
   side_type          side_end;

   assign side_end = side_ff[LC-1];

   always_comb begin
      logic [EW-1:0]  ue;
      logic [MEW-1:0] me;
      for (int i = 0; i < 3; i++) begin
         ue = EW'(uroot[i][KU]);
         if (side_end.neg[i]) begin
            ue = (ue > U_NEG) ? U_NEG : ue;
            ue = -ue;
         end else begin
            ue = (ue > U_POS) ? U_POS : ue;
         end
         norm_in[i] = side_end.use_unit ? W'(ue) : raw_ff[LC-1][i];
      end
      me = MEW'(mroot[KM]);
      me = (me > M_MAX) ? M_MAX : me;
      magnitude_in = side_end.use_unit ? W'(me) : '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         norm_ff      <= norm_in;
         magnitude_ff <= magnitude_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_norm_x    = norm_ff[0];
   assign rsp_norm_y    = norm_ff[1];
   assign rsp_norm_z    = norm_ff[2];
   assign rsp_magnitude = magnitude_ff;

endmodule

`default_nettype wire
